### rtl/ctcg_pkg.sv
// Shared types and constants for the CTC greedy character decoder.
package ctcg_pkg;

    localparam int SCORE_W = 16;
    localparam int CLASS_W = 13;
    localparam int STEP_W  = 8;
    localparam int LEFT_W  = 12;
    localparam int RIGHT_W = 13;
    localparam int SUM_W   = 24;
    localparam int COUNT_W = 9;
    localparam int NLAB_W  = 14;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 2;
    // signed Q18.16 pixel position: step*256 - shift never exceeds 17 bits
    localparam int PROD_W  = 34;

    localparam logic [CLASS_W-1:0] CLASS_MAX = 13'd8191;
    localparam logic [STEP_W-1:0]  STEP_MAX  = 8'd255;
    localparam logic [LEFT_W-1:0]  PIX_MAX   = 12'd4095;
    localparam logic [SUM_W-1:0]   SUM_MAX   = 24'hFF_FFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

    localparam logic [NLAB_W-1:0]        NUM_LABELS_RST = 14'd8192;
    localparam logic [CFG_W-1:0]         SHIFT_RST      = 16'd384;
    localparam logic [CFG_W-1:0]         PPX_RST        = 16'd1280;
    // -(384 * 1280): pixel product of step zero under reset configuration
    localparam logic signed [PROD_W-1:0] BASE_RST       = -34'sd491520;

    localparam logic [CIDX_W-1:0] CFG_NUM_LABELS = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_SHIFT      = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_PPX        = 2'd2;

    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [CLASS_W-1:0] label;
        logic [SCORE_W-1:0] score;
        logic [STEP_W-1:0]  step;
        logic [LEFT_W-1:0]  left_x;
        logic [RIGHT_W-1:0] right_x;
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
        logic               last;
    } t_result;

endpackage

### rtl/ctc_greedy_char_decoder.sv
// CTC greedy character decoder: streaming argmax, label filter, pixel spans, summary.
//
//  channel   dir  handshake                      payload
//  -------   ---  -----------------------------  ----------------------------------------
//  in        in   i_in_valid / o_in_ready        i_class_score, i_step_end, i_sequence_end
//  out       out  o_out_valid / i_out_ready      o_result_kind ... o_last_result
//  cfg       in   i_cfg_we (no wait)             i_cfg_index, i_cfg_data
//
//  A request enters an input register, and when it is processed its results (zero to three)
//  are appended to a three-slot result queue whose head drives the output ports.
//  One request per cycle is accepted while the queue has room for its results, so
//  throughput is one request per cycle, bounded by one result per cycle on the output.
//  The pixel product is tracked by an adder per step; the multipliers run only on
//  configuration writes. Reset is synchronous and clears all control state.
module ctc_greedy_char_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ctcg_pkg::CIDX_W-1:0]    i_cfg_index,
    input  logic [ctcg_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [ctcg_pkg::SCORE_W-1:0]   i_class_score,
    input  logic                           i_step_end,
    input  logic                           i_sequence_end,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_result_kind,
    output logic [ctcg_pkg::CLASS_W-1:0]   o_label_index,
    output logic [ctcg_pkg::SCORE_W-1:0]   o_char_score,
    output logic [ctcg_pkg::STEP_W-1:0]    o_step_index,
    output logic [ctcg_pkg::LEFT_W-1:0]    o_left_x,
    output logic [ctcg_pkg::RIGHT_W-1:0]   o_right_x,
    output logic [ctcg_pkg::SUM_W-1:0]     o_score_sum,
    output logic [ctcg_pkg::COUNT_W-1:0]   o_char_count,
    output logic                           o_last_result
);

    // configuration
    logic [ctcg_pkg::NLAB_W-1:0]        r_num_labels;
    logic [ctcg_pkg::CFG_W-1:0]         r_shift;
    logic [ctcg_pkg::CFG_W-1:0]         r_ppx;
    logic signed [ctcg_pkg::PROD_W-1:0] r_base;
    logic signed [ctcg_pkg::PROD_W-1:0] r_prod;

    // input register
    logic                         r_in_valid;
    logic [ctcg_pkg::SCORE_W-1:0] r_in_score;
    logic                         r_in_step_end;
    logic                         r_in_seq_end;

    // decoder state
    logic [ctcg_pkg::STEP_W-1:0]  r_step;
    logic [ctcg_pkg::CLASS_W-1:0] r_class;
    logic [ctcg_pkg::SCORE_W-1:0] r_best_score;
    logic [ctcg_pkg::CLASS_W-1:0] r_best_class;
    logic [ctcg_pkg::CLASS_W-1:0] r_prev_argmax;
    logic                         r_pend_valid;
    logic [ctcg_pkg::CLASS_W-1:0] r_pend_label;
    logic [ctcg_pkg::SCORE_W-1:0] r_pend_score;
    logic [ctcg_pkg::STEP_W-1:0]  r_pend_step;
    logic [ctcg_pkg::LEFT_W-1:0]  r_pend_start;
    logic [ctcg_pkg::RIGHT_W-1:0] r_prev_gap;
    logic [ctcg_pkg::SUM_W-1:0]   r_sum;
    logic [ctcg_pkg::COUNT_W-1:0] r_count;

    // result queue
    ctcg_pkg::t_result r_res [3];
    logic [1:0]        r_res_cnt;
    ctcg_pkg::t_result n_res [3];
    logic [1:0]        n_res_cnt;

    // configuration multiplies
    logic [ctcg_pkg::CFG_W-1:0]         n_shift;
    logic [ctcg_pkg::CFG_W-1:0]         n_ppx;
    logic [2*ctcg_pkg::CFG_W-1:0]       w_base_mag;
    logic signed [17:0]                 w_pos;
    logic signed [ctcg_pkg::PROD_W-1:0] w_prod_cfg;
    logic signed [ctcg_pkg::PROD_W-1:0] w_inc;

    // datapath
    logic                         w_step_end;
    logic                         w_take;
    logic [ctcg_pkg::SCORE_W-1:0] w_cur_score;
    logic [ctcg_pkg::CLASS_W-1:0] w_cur_class;
    logic                         w_keep;
    logic [ctcg_pkg::LEFT_W-1:0]  w_start;
    logic [ctcg_pkg::RIGHT_W-1:0] w_gap_new;
    logic                         w_pv2;
    logic [ctcg_pkg::CLASS_W-1:0] w_pl2;
    logic [ctcg_pkg::SCORE_W-1:0] w_ps2;
    logic [ctcg_pkg::STEP_W-1:0]  w_pst2;
    logic [ctcg_pkg::LEFT_W-1:0]  w_pstart2;
    logic [ctcg_pkg::RIGHT_W-1:0] w_gap2;
    logic [ctcg_pkg::SUM_W:0]     w_sum_ext;
    logic [ctcg_pkg::SUM_W-1:0]   w_sum2;
    logic [ctcg_pkg::COUNT_W-1:0] w_cnt2;
    logic                         w_emit_a;
    logic                         w_emit_b;
    logic                         w_emit_c;
    logic [1:0]                   w_n_new;
    ctcg_pkg::t_result            w_res_a;
    ctcg_pkg::t_result            w_res_b;
    ctcg_pkg::t_result            w_res_c;
    ctcg_pkg::t_result            w_new [3];
    ctcg_pkg::t_result            w_shifted [3];
    logic                         w_pop;
    logic [1:0]                   w_rem;
    logic                         w_proc;
    logic                         w_in_acc;

    assign w_pop    = o_out_valid && i_out_ready;
    assign w_rem    = r_res_cnt - {1'b0, w_pop};
    assign w_proc   = r_in_valid && ({1'b0, w_rem} + {1'b0, w_n_new} <= 3'd3);
    assign o_in_ready = !r_in_valid || w_proc;
    assign w_in_acc = i_in_valid && o_in_ready;

    // ---------------- configuration ----------------
    always_comb begin
        n_shift = r_shift;
        n_ppx   = r_ppx;
        if (i_cfg_we) begin
            case (i_cfg_index)
                ctcg_pkg::CFG_SHIFT: n_shift = i_cfg_data;
                ctcg_pkg::CFG_PPX:   n_ppx   = i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_base_mag = n_shift * n_ppx;
    assign w_pos      = $signed({2'b00, r_step, 8'h00}) - $signed({2'b00, n_shift});
    assign w_prod_cfg = w_pos * $signed({1'b0, n_ppx});
    assign w_inc      = $signed({10'd0, r_ppx, 8'h00});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_labels <= ctcg_pkg::NUM_LABELS_RST;
            r_shift      <= ctcg_pkg::SHIFT_RST;
            r_ppx        <= ctcg_pkg::PPX_RST;
            r_base       <= ctcg_pkg::BASE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == ctcg_pkg::CFG_NUM_LABELS) begin
                r_num_labels <= i_cfg_data[ctcg_pkg::NLAB_W-1:0];
            end
            r_shift <= n_shift;
            r_ppx   <= n_ppx;
            r_base  <= -$signed({2'b00, w_base_mag});
        end
    end

    // ---------------- per-request datapath ----------------
    always_comb begin
        w_step_end  = r_in_step_end | r_in_seq_end;
        w_take      = (r_class == '0) || (r_in_score > r_best_score);
        w_cur_score = w_take ? r_in_score : r_best_score;
        w_cur_class = w_take ? r_class : r_best_class;
        w_keep = w_step_end && (w_cur_class != '0)
                 && !((r_step != '0) && (w_cur_class == r_prev_argmax))
                 && ({1'b0, w_cur_class} < r_num_labels);

        // clamp negative positions to zero, saturate the integer pixel
        if (r_prod[ctcg_pkg::PROD_W-1]) begin
            w_start = '0;
        end else if (|r_prod[ctcg_pkg::PROD_W-2:28]) begin
            w_start = ctcg_pkg::PIX_MAX;
        end else begin
            w_start = r_prod[27:16];
        end

        w_gap_new = {1'b0, w_start} - {1'b0, r_pend_start};
        w_emit_a  = w_keep && r_pend_valid;

        w_pv2     = r_pend_valid | w_keep;
        w_pl2     = w_keep ? (w_cur_class - 13'd1) : r_pend_label;
        w_ps2     = w_keep ? w_cur_score : r_pend_score;
        w_pst2    = w_keep ? r_step : r_pend_step;
        w_pstart2 = w_keep ? w_start : r_pend_start;
        w_gap2    = w_emit_a ? w_gap_new : r_prev_gap;

        w_sum_ext = {1'b0, r_sum} + {9'd0, w_cur_score};
        if (!w_keep) begin
            w_sum2 = r_sum;
        end else if (w_sum_ext[ctcg_pkg::SUM_W]) begin
            w_sum2 = ctcg_pkg::SUM_MAX;
        end else begin
            w_sum2 = w_sum_ext[ctcg_pkg::SUM_W-1:0];
        end
        w_cnt2 = (w_keep && (r_count != ctcg_pkg::COUNT_MAX)) ? r_count + 9'd1 : r_count;

        w_emit_b = r_in_seq_end && w_pv2;
        w_emit_c = r_in_seq_end;
        w_n_new  = {1'b0, w_emit_a} + {1'b0, w_emit_b} + {1'b0, w_emit_c};

        w_res_a         = '0;
        w_res_a.kind    = ctcg_pkg::KIND_CHAR;
        w_res_a.label   = r_pend_label;
        w_res_a.score   = r_pend_score;
        w_res_a.step    = r_pend_step;
        w_res_a.left_x  = r_pend_start;
        w_res_a.right_x = {1'b0, w_start};
        w_res_a.last    = !r_in_seq_end;

        // last character reuses the previous gap
        w_res_b         = '0;
        w_res_b.kind    = ctcg_pkg::KIND_CHAR;
        w_res_b.label   = w_pl2;
        w_res_b.score   = w_ps2;
        w_res_b.step    = w_pst2;
        w_res_b.left_x  = w_pstart2;
        w_res_b.right_x = {1'b0, w_pstart2} + w_gap2;

        w_res_c       = '0;
        w_res_c.kind  = ctcg_pkg::KIND_SUMMARY;
        w_res_c.sum   = w_sum2;
        w_res_c.count = w_cnt2;
        w_res_c.last  = 1'b1;

        // pack present results to the front
        w_new[0] = w_emit_a ? w_res_a : (w_emit_b ? w_res_b : w_res_c);
        w_new[1] = w_emit_a ? (w_emit_b ? w_res_b : w_res_c) : w_res_c;
        w_new[2] = w_res_c;
    end

    // ---------------- result queue ----------------
    always_comb begin
        w_shifted[0] = w_pop ? r_res[1] : r_res[0];
        w_shifted[1] = w_pop ? r_res[2] : r_res[1];
        w_shifted[2] = r_res[2];
        for (int k = 0; k < 3; k++) begin
            n_res[k] = w_shifted[k];
            if (w_proc && (2'(k) >= w_rem) && ((2'(k) - w_rem) < w_n_new)) begin
                n_res[k] = w_new[2'(k) - w_rem];
            end
        end
        n_res_cnt = w_proc ? (w_rem + w_n_new) : w_rem;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_res[k] <= n_res[k];
        end
        if (w_in_acc) begin
            r_in_score    <= i_class_score;
            r_in_step_end <= i_step_end;
            r_in_seq_end  <= i_sequence_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_cnt  <= '0;
            r_in_valid <= 1'b0;
        end else begin
            r_res_cnt <= n_res_cnt;
            if (w_in_acc) begin
                r_in_valid <= 1'b1;
            end else if (w_proc) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    // ---------------- decoder state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step        <= '0;
            r_class       <= '0;
            r_best_score  <= '0;
            r_best_class  <= '0;
            r_prev_argmax <= '0;
            r_pend_valid  <= 1'b0;
            r_pend_label  <= '0;
            r_pend_score  <= '0;
            r_pend_step   <= '0;
            r_pend_start  <= '0;
            r_prev_gap    <= '0;
            r_sum         <= '0;
            r_count       <= '0;
            r_prod        <= ctcg_pkg::BASE_RST;
        end else if (i_cfg_we) begin
            // rebuild the pixel product for the current step
            r_prod <= w_prod_cfg;
        end else if (w_proc) begin
            if (w_step_end) begin
                r_class      <= '0;
                r_best_score <= '0;
                r_best_class <= '0;
            end else begin
                r_class      <= (r_class != ctcg_pkg::CLASS_MAX) ? r_class + 13'd1 : r_class;
                r_best_score <= w_cur_score;
                r_best_class <= w_cur_class;
            end
            if (r_in_seq_end) begin
                r_step        <= '0;
                r_prod        <= r_base;
                r_prev_argmax <= '0;
                r_pend_valid  <= 1'b0;
                r_pend_label  <= '0;
                r_pend_score  <= '0;
                r_pend_step   <= '0;
                r_pend_start  <= '0;
                r_prev_gap    <= '0;
                r_sum         <= '0;
                r_count       <= '0;
            end else begin
                if (w_step_end) begin
                    r_prev_argmax <= w_cur_class;
                    if (r_step != ctcg_pkg::STEP_MAX) begin
                        r_step <= r_step + 8'd1;
                        r_prod <= r_prod + w_inc;
                    end
                end
                r_pend_valid <= w_pv2;
                r_pend_label <= w_pl2;
                r_pend_score <= w_ps2;
                r_pend_step  <= w_pst2;
                r_pend_start <= w_pstart2;
                r_prev_gap   <= w_gap2;
                r_sum        <= w_sum2;
                r_count      <= w_cnt2;
            end
        end
    end

    // ---------------- outputs ----------------
    assign o_out_valid   = (r_res_cnt != '0);
    assign o_result_kind = r_res[0].kind;
    assign o_label_index = r_res[0].label;
    assign o_char_score  = r_res[0].score;
    assign o_step_index  = r_res[0].step;
    assign o_left_x      = r_res[0].left_x;
    assign o_right_x     = r_res[0].right_x;
    assign o_score_sum   = r_res[0].sum;
    assign o_char_count  = r_res[0].count;
    assign o_last_result = r_res[0].last;

    // ---------------- assertions ----------------
    a_summary_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind == ctcg_pkg::KIND_SUMMARY) |-> o_last_result)
        else $error("summary result not flagged as last");

    a_char_no_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind == ctcg_pkg::KIND_CHAR)
        |-> (o_score_sum == '0) && (o_char_count == '0))
        else $error("character result carries summary fields");

    a_seq_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc && r_in_seq_end && !i_cfg_we |=> (r_step == '0) && !r_pend_valid
        && (r_count == '0))
        else $error("sequence state not cleared after sequence end");

    a_empty_stage_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_in_ready)
        else $error("input stalled with empty input register");

    a_pending_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> !r_pend_valid)
        else $error("pending character without a kept count");

endmodule

### tb/ctc_greedy_char_decoder_tb.sv
// Self-checking testbench for the CTC greedy character decoder.
module ctc_greedy_char_decoder_tb;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 12;
    localparam int IDLE_PERCENT   = 35;
    localparam int HOLD_CYCLES    = 80;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 20;

    typedef struct packed {
        logic [ctcg_pkg::SCORE_W-1:0] score;
        logic                         step_end;
        logic                         seq_end;
    } t_score_req;

    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_cfg_we       = 1'b0;
    logic [ctcg_pkg::CIDX_W-1:0]   i_cfg_index    = ctcg_pkg::CFG_NUM_LABELS;
    logic [ctcg_pkg::CFG_W-1:0]    i_cfg_data     = '0;
    logic                          i_in_valid     = 1'b0;
    logic                          o_in_ready;
    logic [ctcg_pkg::SCORE_W-1:0]  i_class_score  = '0;
    logic                          i_step_end     = 1'b0;
    logic                          i_sequence_end = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_ready    = 1'b0;
    logic                          o_result_kind;
    logic [ctcg_pkg::CLASS_W-1:0]  o_label_index;
    logic [ctcg_pkg::SCORE_W-1:0]  o_char_score;
    logic [ctcg_pkg::STEP_W-1:0]   o_step_index;
    logic [ctcg_pkg::LEFT_W-1:0]   o_left_x;
    logic [ctcg_pkg::RIGHT_W-1:0]  o_right_x;
    logic [ctcg_pkg::SUM_W-1:0]    o_score_sum;
    logic [ctcg_pkg::COUNT_W-1:0]  o_char_count;
    logic                          o_last_result;

    ctc_greedy_char_decoder i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_class_score  (i_class_score),
        .i_step_end     (i_step_end),
        .i_sequence_end (i_sequence_end),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_kind  (o_result_kind),
        .o_label_index  (o_label_index),
        .o_char_score   (o_char_score),
        .o_step_index   (o_step_index),
        .o_left_x       (o_left_x),
        .o_right_x      (o_right_x),
        .o_score_sum    (o_score_sum),
        .o_char_count   (o_char_count),
        .o_last_result  (o_last_result)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    t_score_req         score_requests[$];
    ctcg_pkg::t_result  expected_results[$];

    int requests_taken  = 0;
    int results_checked = 0;
    int sequences_sent  = 0;
    int error_count     = 0;
    int idle_cycles     = 0;
    int hold_left       = 0;
    logic hold_done     = 1'b0;
    logic hold_armed    = 1'b0;
    logic steady        = 1'b0;

    // decoder shadow: configuration and state
    logic [ctcg_pkg::NLAB_W-1:0]  cfg_num_labels = ctcg_pkg::NUM_LABELS_RST;
    logic [ctcg_pkg::CFG_W-1:0]   cfg_shift      = ctcg_pkg::SHIFT_RST;
    logic [ctcg_pkg::CFG_W-1:0]   cfg_ppx        = ctcg_pkg::PPX_RST;
    logic [ctcg_pkg::STEP_W-1:0]  dec_step       = '0;
    logic [ctcg_pkg::CLASS_W-1:0] dec_class      = '0;
    logic [ctcg_pkg::SCORE_W-1:0] dec_best_score = '0;
    logic [ctcg_pkg::CLASS_W-1:0] dec_best_class = '0;
    logic [ctcg_pkg::CLASS_W-1:0] dec_prev_am    = '0;
    logic                         pend_valid     = 1'b0;
    logic [ctcg_pkg::CLASS_W-1:0] pend_label     = '0;
    logic [ctcg_pkg::SCORE_W-1:0] pend_score     = '0;
    logic [ctcg_pkg::STEP_W-1:0]  pend_step      = '0;
    logic [ctcg_pkg::LEFT_W-1:0]  pend_start     = '0;
    logic [ctcg_pkg::RIGHT_W-1:0] prev_gap       = '0;
    logic [ctcg_pkg::SUM_W-1:0]   kept_sum       = '0;
    logic [ctcg_pkg::COUNT_W-1:0] kept_count     = '0;

    function automatic logic [ctcg_pkg::LEFT_W-1:0] char_start_x(
            input logic [ctcg_pkg::STEP_W-1:0] step);
        longint pos;
        longint px;
        pos = longint'(step) * 256 - longint'(cfg_shift);
        if (pos < 0)
            return '0;
        px = (pos * longint'(cfg_ppx)) >> 16;
        return (px > longint'(ctcg_pkg::PIX_MAX)) ? ctcg_pkg::PIX_MAX
                                                   : px[ctcg_pkg::LEFT_W-1:0];
    endfunction

    function automatic ctcg_pkg::t_result char_result(
            input logic [ctcg_pkg::CLASS_W-1:0] label,
            input logic [ctcg_pkg::SCORE_W-1:0] score,
            input logic [ctcg_pkg::STEP_W-1:0]  step,
            input logic [ctcg_pkg::LEFT_W-1:0]  left_x,
            input logic [ctcg_pkg::RIGHT_W-1:0] right_x);
        ctcg_pkg::t_result r;
        r         = '0;
        r.kind    = ctcg_pkg::KIND_CHAR;
        r.label   = label;
        r.score   = score;
        r.step    = step;
        r.left_x  = left_x;
        r.right_x = right_x;
        return r;
    endfunction

    // Advance the shadow decoder by one accepted score and queue what it emits.
    task automatic decode_score(input t_score_req req);
        ctcg_pkg::t_result            batch[$];
        ctcg_pkg::t_result            summary;
        logic                         ends_step;
        logic                         keep;
        logic [ctcg_pkg::CLASS_W-1:0] am;
        logic [ctcg_pkg::LEFT_W-1:0]  st;
        logic [ctcg_pkg::SUM_W:0]     wide_sum;
        ends_step = req.step_end | req.seq_end;
        if (dec_class == '0 || req.score > dec_best_score) begin
            dec_best_score = req.score;
            dec_best_class = dec_class;
        end
        if (dec_class != ctcg_pkg::CLASS_MAX)
            dec_class = dec_class + 1'b1;

        if (ends_step) begin
            am   = dec_best_class;
            keep = (am != '0) && !(dec_step != '0 && am == dec_prev_am)
                   && (int'(am) < int'(cfg_num_labels));
            if (keep) begin
                st = char_start_x(dec_step);
                if (pend_valid) begin
                    batch.insert(batch.size(), char_result(pend_label, pend_score,
                                 pend_step, pend_start, {1'b0, st}));
                    prev_gap = {1'b0, st} - {1'b0, pend_start};
                end
                pend_valid = 1'b1;
                pend_label = am - 1'b1;
                pend_score = dec_best_score;
                pend_step  = dec_step;
                pend_start = st;
                wide_sum   = {1'b0, kept_sum} + {9'd0, dec_best_score};
                kept_sum   = (wide_sum > {1'b0, ctcg_pkg::SUM_MAX}) ? ctcg_pkg::SUM_MAX
                                                                    : wide_sum[ctcg_pkg::SUM_W-1:0];
                if (kept_count != ctcg_pkg::COUNT_MAX)
                    kept_count = kept_count + 1'b1;
            end
            dec_prev_am    = am;
            dec_class      = '0;
            dec_best_score = '0;
            dec_best_class = '0;
            if (dec_step != ctcg_pkg::STEP_MAX)
                dec_step = dec_step + 1'b1;
        end

        if (req.seq_end) begin
            if (pend_valid)
                batch.insert(batch.size(), char_result(pend_label, pend_score, pend_step,
                             pend_start, {1'b0, pend_start} + prev_gap));
            summary       = '0;
            summary.kind  = ctcg_pkg::KIND_SUMMARY;
            summary.sum   = kept_sum;
            summary.count = kept_count;
            batch.insert(batch.size(), summary);
            dec_step    = '0;
            dec_prev_am = '0;
            pend_valid  = 1'b0;
            pend_label  = '0;
            pend_score  = '0;
            pend_step   = '0;
            pend_start  = '0;
            prev_gap    = '0;
            kept_sum    = '0;
            kept_count  = '0;
        end

        if (batch.size() > 0)
            batch[batch.size()-1].last = 1'b1;
        foreach (batch[j])
            expected_results.insert(expected_results.size(), batch[j]);
    endtask

    // Sender: present the next pending request, or idle at random.
    always @(posedge i_clk) begin
        t_score_req nxt;
        logic       advance;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            advance = !i_in_valid || o_in_ready;
            if (i_in_valid && o_in_ready) begin
                decode_score({i_class_score, i_step_end, i_sequence_end});
                requests_taken <= requests_taken + 1;
            end
            if (advance) begin
                if (score_requests.size() > 0 && (steady || hold_left != 0 ||
                        $urandom_range(99) >= IDLE_PERCENT)) begin
                    nxt = score_requests.pop_front();
                    i_in_valid     <= 1'b1;
                    i_class_score  <= nxt.score;
                    i_step_end     <= nxt.step_end;
                    i_sequence_end <= nxt.seq_end;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            error_count = error_count + 1;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Receiver: check each result against the oldest expectation, stall at random.
    always @(posedge i_clk) begin
        ctcg_pkg::t_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    error_count = error_count + 1;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: result with nothing expected, expected none, got kind %0d",
                                 $time, o_result_kind);
                end else begin
                    want = expected_results.pop_front();
                    check_field("result_kind", want.kind, o_result_kind);
                    check_field("label_index", want.label, o_label_index);
                    check_field("char_score", want.score, o_char_score);
                    check_field("step_index", want.step, o_step_index);
                    check_field("left_x", want.left_x, o_left_x);
                    check_field("right_x", want.right_x, o_right_x);
                    check_field("score_sum", want.sum, o_score_sum);
                    check_field("char_count", want.count, o_char_count);
                    check_field("last_result", want.last, o_last_result);
                end
                results_checked <= results_checked + 1;
            end
            if (hold_left != 0) begin
                hold_left   <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else if (hold_armed && !hold_done) begin
                // long stall so the result queue fills and backs up the input
                hold_left   <= HOLD_CYCLES;
                hold_done   <= 1'b1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, idle_cycles);
                $display("ctc_greedy_char_decoder: mismatch");
                $finish;
            end
        end
    end

    task automatic add_request(input logic [ctcg_pkg::SCORE_W-1:0] score,
                               input logic step_end, input logic seq_end);
        t_score_req req;
        req.score    = score;
        req.step_end = step_end;
        req.seq_end  = seq_end;
        score_requests.insert(score_requests.size(), req);
    endtask

    function automatic logic [ctcg_pkg::SCORE_W-1:0] pick_score();
        case ($urandom_range(3))
            0:       return ctcg_pkg::SCORE_W'($urandom_range(0, 65535));
            1:       return '0;
            2:       return '1;
            default: return ctcg_pkg::SCORE_W'($urandom_range(0, 3));   // ties are likely
        endcase
    endfunction

    // One well-formed sequence; the closing score may or may not carry step_end.
    task automatic add_random_sequence(output int made);
        int steps;
        int classes;
        logic last;
        steps = $urandom_range(1, 8);
        made  = 0;
        for (int s = 0; s < steps; s++) begin
            classes = $urandom_range(1, 6);
            for (int c = 0; c < classes; c++) begin
                last = (c == classes - 1);
                add_request(pick_score(), last && (s < steps - 1 || $urandom_range(1) == 1),
                            last && (s == steps - 1));
                made++;
            end
        end
        sequences_sent++;
    endtask

    task automatic add_random_phase(input int budget);
        int made;
        int total;
        total = 0;
        while (total < budget) begin
            add_random_sequence(made);
            total += made;
        end
    endtask

    // Wait until every request is taken and every result has come, then settle.
    task automatic drain();
        @(negedge i_clk);
        while (score_requests.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [ctcg_pkg::CIDX_W-1:0] index,
                             input logic [ctcg_pkg::CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [ctcg_pkg::CFG_W-1:0] labels,
                              input logic [ctcg_pkg::CFG_W-1:0] shift,
                              input logic [ctcg_pkg::CFG_W-1:0] ppx);
        write_reg(ctcg_pkg::CFG_NUM_LABELS, labels);
        write_reg(ctcg_pkg::CFG_SHIFT, shift);
        write_reg(ctcg_pkg::CFG_PPX, ppx);
        i_cfg_we       <= 1'b0;
        cfg_num_labels  = labels[ctcg_pkg::NLAB_W-1:0];
        cfg_shift       = shift;
        cfg_ppx         = ppx;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration: blank-only sequence, ties, blank between repeats,
        // dropped repeat, sequence end without step end, single character
        add_request(16'd0, 1'b0, 1'b1);
        add_request(16'd100, 1'b0, 1'b0);
        add_request(16'hFFFF, 1'b1, 1'b0);
        repeat (2) add_request(16'd5, 1'b0, 1'b0);
        add_request(16'd5, 1'b1, 1'b0);
        add_request(16'd0, 1'b0, 1'b0);
        add_request(16'd9, 1'b0, 1'b0);
        add_request(16'd9, 1'b1, 1'b0);
        add_request(16'd0, 1'b0, 1'b0);
        add_request(16'd7, 1'b1, 1'b0);
        add_request(16'd1, 1'b0, 1'b0);
        add_request(16'd2, 1'b0, 1'b0);
        add_request(16'd3, 1'b0, 1'b0);
        add_request(16'hFFFF, 1'b0, 1'b1);
        add_request(16'd0, 1'b0, 1'b0);
        add_request(16'hFFFF, 1'b1, 1'b1);
        sequences_sent += 3;
        drain();

        // saturating pixel starts; blank steps between repeats of class one
        set_config(16'd8192, 16'd0, 16'hFFFF);
        steady <= 1'b1;
        for (int s = 0; s < 20; s++) begin
            add_request(16'd0, 1'b0, 1'b0);
            add_request((s % 2 == 0) ? 16'hFFFF : 16'd0, s != 19, s == 19);
        end
        sequences_sent += 1;
        drain();
        steady <= 1'b0;

        // zero label set: only summaries come out
        set_config(16'd0, 16'hFFFF, 16'd0);
        add_random_phase(20);
        drain();

        // narrow label set drops high classes
        set_config(16'd3, 16'd256, 16'd300);
        add_random_phase(45);
        drain();

        set_config(16'd5, ctcg_pkg::CFG_W'($urandom_range(0, 1023)),
                   ctcg_pkg::CFG_W'($urandom_range(0, 65535)));
        hold_armed <= 1'b1;
        add_random_phase(75);
        drain();

        $display("covered %0d score requests in %0d sequences, %0d results checked",
                 requests_taken, sequences_sent, results_checked);
        $display("incl. pixel clamping and saturation, an empty label set and a long output stall");
        if (error_count == 0)
            $display("ctc_greedy_char_decoder: match");
        else
            $display("ctc_greedy_char_decoder: mismatch");
        $finish;
    end

endmodule
